/* sv/dts_pkg.sv */
package dts_pkg;

    // fixed field widths
    localparam int RDEV_W   = 32;
    localparam int INODE_W  = 64;
    localparam int ENTRY_W  = RDEV_W + INODE_W;
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int TYPE_W   = 2;

    // default table depth
    localparam int TABLE_DEPTH_DEF = 1024;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DEVICE_OF_DEV = 1'b0;
    localparam logic REG_ENTRY_COUNT   = 1'b1;

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // inode type that turns on the inode comparison
    localparam logic [TYPE_W-1:0] INODE_TYPE_CMP = 2'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_DONE
    } dts_state_t;

    typedef struct packed {
        logic [RDEV_W-1:0]  device_of_dev;
        logic [COUNT_W-1:0] entry_count;
    } dts_cfg_t;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] match_index;
    } dts_result_t;

endpackage

/* sv/dts_ram.sv */
module dts_ram
    import dts_pkg::*;
#(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/dts_search.sv */
module dts_search
    import dts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  dts_cfg_t                         cfg,
    // input transaction
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [INDEX_W-1:0]               entry_index,
    input  logic [RDEV_W-1:0]                entry_rdev,
    input  logic [INODE_W-1:0]               entry_inode,
    input  logic [RDEV_W-1:0]                device_id,
    input  logic [RDEV_W-1:0]                raw_device,
    input  logic                             match_inode,
    input  logic [INODE_W-1:0]               file_inode,
    input  logic [TYPE_W-1:0]                inode_type,
    // result handoff
    output logic                             res_valid,
    input  logic                             res_ready,
    output dts_result_t                      res,
    // table memory
    output logic                             ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]   ram_waddr,
    output logic [ENTRY_W-1:0]               ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]   ram_raddr,
    input  logic [ENTRY_W-1:0]               ram_rdata
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = (AW + 1 > INDEX_W) ? AW + 1 : INDEX_W;
    localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
    localparam int MW = (AW > INDEX_W) ? AW : INDEX_W;

    dts_state_t         state_reg, state_next;
    logic [AW:0]        low_reg, low_next;
    logic [AW:0]        hix_reg, hix_next;
    logic [AW-1:0]      mid_reg, mid_next;
    logic [RDEV_W-1:0]  key_rdev_reg, key_rdev_next;
    logic [INODE_W-1:0] key_inode_reg, key_inode_next;
    logic               chk_inode_reg, chk_inode_next;
    dts_result_t        res_reg, res_next;

    logic [LW-1:0]      idx_ext;
    logic               idx_ok;
    logic [CW-1:0]      cnt_ext;
    logic [CW-1:0]      cnt_sat;
    logic [AW:0]        n_entries;
    logic [AW+1:0]      mid_sum;
    logic [MW-1:0]      mid_ext;
    logic [RDEV_W-1:0]  e_rdev;
    logic [INODE_W-1:0] e_inode;

    // load address range check
    assign idx_ext   = LW'(entry_index);
    assign idx_ok    = idx_ext < LW'(TABLE_DEPTH);
    assign ram_waddr = idx_ext[AW-1:0];
    assign ram_wdata = {entry_rdev, entry_inode};

    // search bound, count saturated at table depth
    assign cnt_ext   = CW'(cfg.entry_count);
    assign cnt_sat   = (cnt_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : cnt_ext;
    assign n_entries = cnt_sat[AW:0];

    // probe midpoint over [low, hix)
    assign mid_sum   = {1'b0, low_reg} + {1'b0, hix_reg} - {{(AW+1){1'b0}}, 1'b1};
    assign ram_raddr = mid_sum[AW:1];
    assign mid_ext   = MW'(mid_reg);

    assign e_rdev  = ram_rdata[ENTRY_W-1:INODE_W];
    assign e_inode = ram_rdata[INODE_W-1:0];

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // search datapath registers
    always_ff @(posedge aclk) begin
        low_reg       <= low_next;
        hix_reg       <= hix_next;
        mid_reg       <= mid_next;
        key_rdev_reg  <= key_rdev_next;
        key_inode_reg <= key_inode_next;
        chk_inode_reg <= chk_inode_next;
        res_reg       <= res_next;
    end

    // sequencer: one probe is a read state and a compare state
    always_comb begin
        state_next     = state_reg;
        low_next       = low_reg;
        hix_next       = hix_reg;
        mid_next       = mid_reg;
        key_rdev_next  = key_rdev_reg;
        key_inode_next = key_inode_reg;
        chk_inode_next = chk_inode_reg;
        res_next       = res_reg;
        ram_we         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    res_next       = '0;
                    low_next       = '0;
                    hix_next       = n_entries;
                    key_rdev_next  = raw_device;
                    key_inode_next = file_inode;
                    chk_inode_next = match_inode && (inode_type == INODE_TYPE_CMP);
                    if (operation == OP_LOAD) begin
                        ram_we     = idx_ok;
                        state_next = ST_DONE;
                    end else if (device_id != cfg.device_of_dev || n_entries == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                mid_next   = mid_sum[AW:1];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (key_rdev_reg < e_rdev) begin
                    hix_next = {1'b0, mid_reg};
                end else if (key_rdev_reg > e_rdev) begin
                    low_next = {1'b0, mid_reg} + {{AW{1'b0}}, 1'b1};
                end else if (!chk_inode_reg || key_inode_reg == e_inode) begin
                    res_next.found       = 1'b1;
                    res_next.match_index = mid_ext[INDEX_W-1:0];
                end else if (key_inode_reg < e_inode) begin
                    hix_next = {1'b0, mid_reg};
                end else begin
                    low_next = {1'b0, mid_reg} + {{AW{1'b0}}, 1'b1};
                end
                if (res_next.found || low_next >= hix_next) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/device_table_search.sv */
// Device table search
//
// Holds a table of (raw device, inode) entries, sorted by raw device and
// then inode, and answers lookups with a binary search over it.
// Input channel (s_*): one transaction is a load (writes one entry) or a
// lookup. Result channel (m_*): exactly one transaction per input, in order;
// loads and misses return found = 0 and match_index = 0.
// APB port: register 0 at 0x0 is device_of_dev, register 1 at 0x4 is
// entry_count; write them only while the block is idle.
// Path: a load or a device mismatch sends the sequencer to its done state,
// then the result enters the output register behind m_valid; a lookup
// first runs probes (one table read, one compare), log2(TABLE_DEPTH)+1 at most.
// Items are worked one at a time: s_ready returns in the cycle after the
// result moves into the output register, so a new item is taken only after
// the result of the last one has left the sequencer.
// The output register holds the result while m_ready is low; one more item
// may be taken and worked, then s_ready stays low until the slot frees.
// Reset clears both registers and the handshake state; table contents stay
// undefined until loaded.
module device_table_search
    import dts_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_operation,
    input  logic [INDEX_W-1:0]    s_entry_index,
    input  logic [RDEV_W-1:0]     s_entry_rdev,
    input  logic [INODE_W-1:0]    s_entry_inode,
    input  logic [RDEV_W-1:0]     s_device_id,
    input  logic [RDEV_W-1:0]     s_raw_device,
    input  logic                  s_match_inode,
    input  logic [INODE_W-1:0]    s_file_inode,
    input  logic [TYPE_W-1:0]     s_inode_type,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_found,
    output logic [INDEX_W-1:0]    m_match_index
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

    dts_cfg_t           cfg_reg;
    logic               reg_idx;
    logic               cfg_wr;

    logic               res_valid;
    logic               res_ready;
    dts_result_t        res;

    logic               m_valid_reg;
    dts_result_t        m_res_reg;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // configuration registers
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_DEVICE_OF_DEV: cfg_reg.device_of_dev <= pwdata[RDEV_W-1:0];
                REG_ENTRY_COUNT:   cfg_reg.entry_count   <= pwdata[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            REG_DEVICE_OF_DEV: prdata = cfg_reg.device_of_dev;
            REG_ENTRY_COUNT:   prdata = APB_DATA_W'(cfg_reg.entry_count);
            default:           prdata = '0;
        endcase
    end

    // entry table
    dts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // search sequencer
    dts_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .operation   (s_operation),
        .entry_index (s_entry_index),
        .entry_rdev  (s_entry_rdev),
        .entry_inode (s_entry_inode),
        .device_id   (s_device_id),
        .raw_device  (s_raw_device),
        .match_inode (s_match_inode),
        .file_inode  (s_file_inode),
        .inode_type  (s_inode_type),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // output register, refilled in the cycle it is taken
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_res_reg.found;
    assign m_match_index = m_res_reg.match_index;

    // the sequencer never takes an item while holding a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !res_valid)
        else $error("input taken while a result is pending");

    // a load answers in the next cycle with a miss
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_operation == OP_LOAD |=> res_valid && !res.found)
        else $error("load did not produce an empty result");

    // a hit lies inside the valid part of the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.found |-> CW'(res.match_index) < CW'(cfg_reg.entry_count))
        else $error("hit index beyond entry count");

    // a miss carries index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_res_reg.found |-> m_res_reg.match_index == '0)
        else $error("miss with nonzero index");

endmodule

/* verif/testbench.sv */
module testbench;
    import dts_pkg::*;

    localparam int DEPTH         = TABLE_DEPTH_DEF;
    localparam int FILL_ENTRIES  = 256;
    localparam int RANDOM_ITEMS  = 360;
    localparam int CALM_ITEMS    = 70;
    localparam int QUIET_LIMIT   = 2000;
    localparam int LINGER_CYCLES = 40;

    localparam logic [APB_ADDR_W-1:0] ADDR_DEVICE = APB_ADDR_W'(4 * REG_DEVICE_OF_DEV);
    localparam logic [APB_ADDR_W-1:0] ADDR_COUNT  = APB_ADDR_W'(4 * REG_ENTRY_COUNT);

    // inode type codes that leave the inode comparison off
    localparam logic [TYPE_W-1:0] TYPE_OTHER_LO  = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_OTHER_MID = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_OTHER_HI  = 2'd3;

    localparam logic [RDEV_W-1:0]  RDEV_MAX  = {RDEV_W{1'b1}};
    localparam logic [INODE_W-1:0] INODE_MAX = {INODE_W{1'b1}};

    typedef struct {
        logic               op;
        logic [INDEX_W-1:0] entry_index;
        logic [RDEV_W-1:0]  entry_rdev;
        logic [INODE_W-1:0] entry_inode;
        logic [RDEV_W-1:0]  device_id;
        logic [RDEV_W-1:0]  raw_device;
        logic               match_inode;
        logic [INODE_W-1:0] file_inode;
        logic [TYPE_W-1:0]  inode_type;
    } dev_request_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CONFIG,
        ROW_FILL
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        dev_request_t           req;
        logic                   has_answer;
        dts_result_t            answer;
        logic [APB_ADDR_W-1:0]  addr;
        logic [APB_DATA_W-1:0]  value;
    } script_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_operation = OP_LOAD;
    logic [INDEX_W-1:0]    s_entry_index = '0;
    logic [RDEV_W-1:0]     s_entry_rdev = '0;
    logic [INODE_W-1:0]    s_entry_inode = '0;
    logic [RDEV_W-1:0]     s_device_id = '0;
    logic [RDEV_W-1:0]     s_raw_device = '0;
    logic                  s_match_inode = 1'b0;
    logic [INODE_W-1:0]    s_file_inode = '0;
    logic [TYPE_W-1:0]     s_inode_type = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_found;
    logic [INDEX_W-1:0]    m_match_index;

    device_table_search DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_entry_index (s_entry_index),
        .s_entry_rdev  (s_entry_rdev),
        .s_entry_inode (s_entry_inode),
        .s_device_id   (s_device_id),
        .s_raw_device  (s_raw_device),
        .s_match_inode (s_match_inode),
        .s_file_inode  (s_file_inode),
        .s_inode_type  (s_inode_type),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_index (m_match_index)
    );

    // shadow of the device table and registers
    logic [RDEV_W-1:0]  tbl_rdev  [DEPTH];
    logic [INODE_W-1:0] tbl_inode [DEPTH];
    logic [RDEV_W-1:0]  cfg_device = '0;
    logic [COUNT_W-1:0] cfg_count = '0;

    dts_result_t  pending_results [$];
    script_row_t  script [$];
    dts_result_t  want;

    bit feeding   = 1'b0;
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;
    int hold_left = 0;
    int errors    = 0;
    int loads_sent = 0;
    int lookups_sent = 0;
    int hits_seen = 0;
    int settings_used = 0;
    int quiet = 0;

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // predicts one transaction's result and updates the table shadow on loads
    function automatic dts_result_t search_table(dev_request_t req);
        dts_result_t        res;
        logic [INODE_W-1:0] key_inode;
        logic [TYPE_W-1:0]  key_type;
        int                 lo;
        int                 hi;
        int                 mid;
        res = '0;
        if (req.op == OP_LOAD) begin
            tbl_rdev[req.entry_index]  = req.entry_rdev;
            tbl_inode[req.entry_index] = req.entry_inode;
            return res;
        end
        if (req.device_id != cfg_device)
            return res;
        key_inode = req.match_inode ? req.file_inode : '0;
        key_type  = req.match_inode ? req.inode_type : TYPE_OTHER_LO;
        lo = 0;
        hi = (int'(cfg_count) > DEPTH ? DEPTH : int'(cfg_count)) - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (req.raw_device < tbl_rdev[mid]) begin
                hi = mid - 1;
            end else if (req.raw_device > tbl_rdev[mid]) begin
                lo = mid + 1;
            end else if (!req.match_inode || key_type != INODE_TYPE_CMP ||
                         key_inode == tbl_inode[mid]) begin
                res.found       = 1'b1;
                res.match_index = INDEX_W'(mid);
                return res;
            end else if (key_inode < tbl_inode[mid]) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    function automatic dev_request_t make_load(int idx, logic [RDEV_W-1:0] rdev,
                                               logic [INODE_W-1:0] inode);
        dev_request_t req;
        req = '{op: OP_LOAD, entry_index: INDEX_W'(idx), entry_rdev: rdev,
                entry_inode: inode, device_id: $urandom, raw_device: $urandom,
                match_inode: 1'($urandom_range(0, 1)), file_inode: {$urandom, $urandom},
                inode_type: TYPE_W'($urandom_range(0, 3))};
        return req;
    endfunction

    function automatic dev_request_t make_lookup(logic [RDEV_W-1:0] dev,
                                                 logic [RDEV_W-1:0] rdev, logic cmp,
                                                 logic [INODE_W-1:0] inode,
                                                 logic [TYPE_W-1:0] itype);
        dev_request_t req;
        req = '{op: OP_LOOKUP, entry_index: INDEX_W'($urandom_range(0, DEPTH - 1)),
                entry_rdev: $urandom, entry_inode: {$urandom, $urandom},
                device_id: dev, raw_device: rdev, match_inode: cmp,
                file_inode: inode, inode_type: itype};
        return req;
    endfunction

    // directed script rows
    function automatic void add_item(dev_request_t req);
        script.push_back('{kind: ROW_ITEM, req: req, has_answer: 1'b0, answer: '0,
                           addr: '0, value: '0});
    endfunction

    function automatic void add_checked(dev_request_t req, logic found,
                                        logic [INDEX_W-1:0] idx);
        script.push_back('{kind: ROW_ITEM, req: req, has_answer: 1'b1,
                           answer: '{found: found, match_index: idx},
                           addr: '0, value: '0});
    endfunction

    function automatic void add_cfg(logic [APB_ADDR_W-1:0] addr,
                                    logic [APB_DATA_W-1:0] value);
        script.push_back('{kind: ROW_CONFIG, req: make_load(0, '0, '0), has_answer: 1'b0,
                           answer: '0, addr: addr, value: value});
    endfunction

    // sends one transaction and queues its expected result at acceptance
    task automatic push_item(dev_request_t req, logic use_answer, dts_result_t answer);
        dts_result_t predicted;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            if (feeding)
                s_valid <= 1'b0;
            feeding = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= req.op;
        s_entry_index <= req.entry_index;
        s_entry_rdev  <= req.entry_rdev;
        s_entry_inode <= req.entry_inode;
        s_device_id   <= req.device_id;
        s_raw_device  <= req.raw_device;
        s_match_inode <= req.match_inode;
        s_file_inode  <= req.file_inode;
        s_inode_type  <= req.inode_type;
        feeding = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = search_table(req);
        pending_results.push_back(use_answer ? answer : predicted);
        if (req.op == OP_LOAD)
            loads_sent++;
        else
            lookups_sent++;
    endtask

    // stop feeding and wait for every outstanding result
    task automatic settle();
        if (feeding)
            s_valid <= 1'b0;
        feeding = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // two-phase register write
    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == ADDR_DEVICE)
            cfg_device = value[RDEV_W-1:0];
        else if (addr == ADDR_COUNT)
            cfg_count = value[COUNT_W-1:0];
        settings_used++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // rewrite the first n entries with sorted random contents
    task automatic reload_sorted(int n);
        logic [RDEV_W-1:0]  rdev;
        logic [INODE_W-1:0] inode;
        logic [RDEV_W:0]    sum;
        rdev  = $urandom >> $urandom_range(0, 31);
        inode = {$urandom, $urandom} >> $urandom_range(0, 63);
        for (int k = 0; k < n; k++) begin
            if (k > 0) begin
                if ($urandom_range(0, 2) == 0) begin
                    inode = inode + $urandom_range(1, 1000);
                end else begin
                    sum = {1'b0, rdev} + $urandom_range(1, 1 << $urandom_range(0, 24));
                    if (!sum[RDEV_W])
                        rdev = sum[RDEV_W-1:0];
                    inode = {$urandom, $urandom} >> $urandom_range(0, 63);
                end
            end
            push_item(make_load(k, rdev, inode), 1'b0, '0);
        end
    endtask

    // lookup aimed mostly at keys that are in the table
    function automatic dev_request_t random_lookup(int n);
        dev_request_t req;
        int           nn;
        int           sel;
        int           j;
        nn  = n > DEPTH ? DEPTH : n;
        sel = $urandom_range(0, 99);
        req = make_lookup($urandom, $urandom, 1'($urandom_range(0, 1)), {$urandom, $urandom},
                          TYPE_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) != 0)
            req.device_id = cfg_device;
        if (nn > 0 && sel < 75) begin
            j = $urandom_range(0, nn - 1);
            req.raw_device  = tbl_rdev[j];
            req.match_inode = $urandom_range(0, 4) != 0;
            if ($urandom_range(0, 9) < 6)
                req.inode_type = INODE_TYPE_CMP;
            case ($urandom_range(0, 3))
                0, 1: req.file_inode = tbl_inode[j];
                2: req.file_inode = tbl_inode[j] + 1;
                default: req.file_inode = tbl_inode[j] - 1;
            endcase
            if (sel >= 60)
                req.raw_device = $urandom_range(0, 1) ? tbl_rdev[j] + 1 : tbl_rdev[j] - 1;
        end
        return req;
    endfunction

    // result side stalls
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stalls_on && $urandom_range(0, 7) == 0) begin
            m_ready   <= 1'b0;
            hold_left <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result found=%0b index=%0d", $time, m_found,
                         m_match_index);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_found !== want.found) begin
                    $display("%0t: found mismatch expected %0b actual %0b", $time,
                             want.found, m_found);
                    errors++;
                end
                if (m_match_index !== want.match_index) begin
                    $display("%0t: match_index mismatch expected %0d actual %0d", $time,
                             want.match_index, m_match_index);
                    errors++;
                end
                if (m_found === 1'b1)
                    hits_seen++;
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("device_table_search regression: fail");
        $finish;
    end

    // stimulus
    initial begin
        int n;
        int base;
        int lookups;
        int lo;
        int hi;
        int mid;
        logic [APB_DATA_W-1:0] dev;

        // after reset both registers are zero: lookups miss without touching the table
        add_checked(make_lookup('0, '0, 1'b0, '0, TYPE_OTHER_LO), 1'b0, '0);
        add_checked(make_load(0, '0, '0), 1'b0, '0);
        add_checked(make_load(DEPTH - 1, RDEV_MAX, INODE_MAX), 1'b0, '0);
        add_checked(make_lookup(32'h1, '0, 1'b1, '0, INODE_TYPE_CMP), 1'b0, '0);
        // low part of the table plus the path to the top entry, four inodes per
        // raw device; full-size lookups below only walk written entries
        script.push_back('{kind: ROW_FILL, req: make_load(0, '0, '0), has_answer: 1'b0,
                           answer: '0, addr: '0, value: '0});
        add_checked(make_load(0, '0, '0), 1'b0, '0);
        add_checked(make_load(DEPTH - 1, RDEV_MAX, INODE_MAX), 1'b0, '0);
        add_cfg(ADDR_DEVICE, RDEV_MAX);
        add_cfg(ADDR_COUNT, DEPTH);
        add_checked(make_lookup(RDEV_MAX, RDEV_MAX, 1'b1, INODE_MAX, INODE_TYPE_CMP), 1'b1,
                    INDEX_W'(DEPTH - 1));
        add_checked(make_lookup('0, 32'h1f, 1'b0, '0, TYPE_OTHER_LO), 1'b0, '0);
        add_item(make_lookup(RDEV_MAX, '0, 1'b1, '0, INODE_TYPE_CMP));
        add_item(make_lookup(RDEV_MAX, 32'h1f, 1'b0, '0, TYPE_OTHER_LO));
        add_item(make_lookup(RDEV_MAX, 32'h1f, 1'b1, 64'd5, INODE_TYPE_CMP));
        add_item(make_lookup(RDEV_MAX, 32'h1f, 1'b1, 64'd4, INODE_TYPE_CMP));
        add_item(make_lookup(RDEV_MAX, 32'h1f, 1'b1, 64'd4, TYPE_OTHER_MID));
        add_item(make_lookup(RDEV_MAX, 32'h1f, 1'b1, 64'd0, TYPE_OTHER_HI));
        add_item(make_lookup(RDEV_MAX, 32'h1f, 1'b1, 64'd2, TYPE_OTHER_LO));
        add_item(make_lookup(RDEV_MAX, 32'h1f, 1'b0, 64'd4, INODE_TYPE_CMP));
        add_item(make_lookup(RDEV_MAX, 32'd300, 1'b0, '0, TYPE_OTHER_LO));
        add_item(make_lookup(RDEV_MAX, 32'h1f, 1'b1, INODE_MAX, INODE_TYPE_CMP));
        // single entry table
        add_cfg(ADDR_DEVICE, '0);
        add_cfg(ADDR_COUNT, 1);
        add_item(make_lookup('0, '0, 1'b1, '0, INODE_TYPE_CMP));
        add_item(make_lookup('0, 32'h1, 1'b0, '0, TYPE_OTHER_LO));
        // empty table
        add_cfg(ADDR_COUNT, 0);
        add_checked(make_lookup('0, '0, 1'b0, '0, TYPE_OTHER_LO), 1'b0, '0);
        // count above the table depth is clamped
        add_cfg(ADDR_DEVICE, 32'h5a5a_a5a5);
        add_cfg(ADDR_COUNT, 1500);
        add_item(make_lookup(32'h5a5a_a5a5, RDEV_MAX, 1'b0, '0, TYPE_OTHER_LO));
        add_item(make_lookup(32'h5a5a_a5a5, 32'd50, 1'b1, 64'd3, INODE_TYPE_CMP));

        // reset
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part
        foreach (script[r]) begin
            case (script[r].kind)
                ROW_CONFIG: begin
                    settle();
                    apb_write(script[r].addr, script[r].value);
                end
                ROW_FILL: begin
                    for (int i = 0; i < FILL_ENTRIES; i++)
                        push_item(make_load(i, RDEV_W'(i >> 2), INODE_W'(2 * (i & 3) + 1)),
                                  1'b0, '0);
                    // upper entries probed by a full-size search for the largest key
                    lo = 0;
                    hi = DEPTH - 1;
                    while (lo <= hi) begin
                        mid = (lo + hi) / 2;
                        if (mid >= FILL_ENTRIES)
                            push_item(make_load(mid, RDEV_W'(mid >> 2),
                                                INODE_W'(2 * (mid & 3) + 1)), 1'b0, '0);
                        lo = mid + 1;
                    end
                end
                default: begin
                    push_item(script[r].req, script[r].has_answer, script[r].answer);
                end
            endcase
        end

        // random phases, each under one register setting
        base = loads_sent + lookups_sent;
        while (loads_sent + lookups_sent - base < RANDOM_ITEMS) begin
            settle();
            if (loads_sent + lookups_sent - base >= RANDOM_ITEMS - CALM_ITEMS) begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end else begin
                gaps_on   = $urandom_range(0, 2) != 0;
                stalls_on = $urandom_range(0, 2) != 0;
            end
            case ($urandom_range(0, 5))
                0: dev = '0;
                1: dev = RDEV_MAX;
                2, 3: dev = cfg_device;
                default: dev = $urandom;
            endcase
            // sizes stay inside the fully written low part of the table
            case ($urandom_range(0, 19))
                0, 1: n = 0;
                2, 3: n = FILL_ENTRIES;
                4: n = $urandom_range(41, FILL_ENTRIES);
                default: n = $urandom_range(1, 40);
            endcase
            apb_write(ADDR_DEVICE, dev);
            apb_write(ADDR_COUNT, n);
            if (n > 0 && n <= 64 && $urandom_range(0, 3) != 0)
                reload_sorted(n);
            lookups = $urandom_range(8, 30);
            for (int k = 0; k < lookups; k++) begin
                if ($urandom_range(0, 99) < 12)
                    push_item(make_load($urandom_range(0, DEPTH - 1), $urandom,
                                        {$urandom, $urandom}), 1'b0, '0);
                else
                    push_item(random_lookup(n), 1'b0, '0);
            end
        end

        // drain
        settle();
        repeat (LINGER_CYCLES) @(posedge aclk);
        $display("covered %0d loads and %0d lookups (%0d hits) over %0d register writes",
                 loads_sent, lookups_sent, hits_seen, settings_used);
        $display("including empty, single entry, full and clamped table sizes");
        if (errors == 0)
            $display("device_table_search regression: pass");
        else
            $display("device_table_search regression: fail");
        $finish;
    end

endmodule
